>>> hdl/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg
// Shared widths, codes and types for the fixed-length frame deframer.
// ----------------------------------------------------------------------------
package fld_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 2;

    // largest value the length register can hold
    localparam int LEN_REG_MAX = (1 << LEN_W) - 1;

    // configuration register indexes
    localparam logic [CFG_W-1:0] REG_START_BYTE     = 2'd0;
    localparam logic [CFG_W-1:0] REG_END_BYTE       = 2'd1;
    localparam logic [CFG_W-1:0] REG_PAYLOAD_LENGTH = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] START_BYTE_RST     = 8'd2;
    localparam logic [BYTE_W-1:0] END_BYTE_RST       = 8'd3;
    localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RST = 11'd256;

    typedef enum logic [STAT_W-1:0] {
        ST_IGNORED     = 3'd0,
        ST_START       = 3'd1,
        ST_PAYLOAD     = 3'd2,
        ST_ACCEPTED    = 3'd3,
        ST_BAD_RESTART = 3'd4,
        ST_BAD_DISCARD = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_READ   = 3'b010,
        PH_FOOTER = 3'b100
    } phase_t;

    // byte moving from the input register into the frame logic
    typedef struct packed {
        logic              advance;
        logic [BYTE_W-1:0] data;
    } in_xfer_t;

    // one result item
    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic              last_payload;
    } result_t;

endpackage

>>> hdl/fld_in_stage.sv
// ----------------------------------------------------------------------------
// fld_in_stage
// Input register for received bytes, advances when the result side has room.
// ----------------------------------------------------------------------------
module fld_in_stage
    import fld_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              out_room,
    output in_xfer_t          xfer
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              take;

    assign in_stall     = valid_reg && !out_room;
    assign take         = in_valid && !in_stall;
    assign xfer.advance = valid_reg && out_room;
    assign xfer.data    = data_reg;
    assign valid_next   = take || (valid_reg && !out_room);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= rx_byte;
        end
    end

endmodule

>>> hdl/fld_frame_fsm.sv
// ----------------------------------------------------------------------------
// fld_frame_fsm
// Frame phase and byte count; decodes one byte into one result per transfer.
// ----------------------------------------------------------------------------
module fld_frame_fsm
    import fld_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  in_xfer_t          xfer,
    input  logic [BYTE_W-1:0] start_byte,
    input  logic [BYTE_W-1:0] end_byte,
    input  logic [LEN_W-1:0]  payload_length,
    output result_t           res
);

    // longest length that can take effect
    localparam int EFF_MAX = (MAX_FRAME_BYTES < LEN_REG_MAX) ? MAX_FRAME_BYTES : LEN_REG_MAX;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);
    localparam logic [LEN_W-1:0] EFF_MAX_L = LEN_W'(EFF_MAX);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   count_inc;
    logic [LEN_W-1:0]   count_wide;
    logic [LEN_W-1:0]   len_full;
    logic [CNT_W-1:0]   len;

    // zero acts as one, above the maximum clamps to it
    always_comb
    begin
        priority if (payload_length == '0)
        begin
            len_full = LEN_W'(1);
        end
        else if (payload_length > EFF_MAX_L)
        begin
            len_full = EFF_MAX_L;
        end
        else
        begin
            len_full = payload_length;
        end
    end

    assign len        = CNT_W'(len_full);
    assign count_inc  = count_reg + CNT_W'(1);
    assign count_wide = LEN_W'(count_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        count_next        = count_reg;
        res.status        = ST_IGNORED;
        res.payload_byte  = '0;
        res.payload_index = '0;
        res.last_payload  = 1'b0;
        unique case (phase_reg)
            PH_READ:
            begin
                res.status        = ST_PAYLOAD;
                res.payload_byte  = xfer.data;
                res.payload_index = count_wide[IDX_W-1:0];
                count_next        = count_inc;
                if (count_inc >= len)
                begin
                    res.last_payload = 1'b1;
                    phase_next       = PH_FOOTER;
                end
            end
            PH_FOOTER:
            begin
                // end byte wins when both delimiters match
                priority if (xfer.data == end_byte)
                begin
                    res.status = ST_ACCEPTED;
                    phase_next = PH_HUNT;
                end
                else if (xfer.data == start_byte)
                begin
                    res.status = ST_BAD_RESTART;
                    phase_next = PH_READ;
                    count_next = '0;
                end
                else
                begin
                    res.status = ST_BAD_DISCARD;
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (xfer.data == start_byte)
                begin
                    res.status = ST_START;
                    phase_next = PH_READ;
                    count_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end
        else if (xfer.advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    a_last_to_footer: assert property (@(posedge clk) disable iff (!rst_n)
        xfer.advance && res.status == ST_PAYLOAD && res.last_payload
        |=> phase_reg == PH_FOOTER)
        else $error("last payload byte did not move to footer phase");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        xfer.advance && (res.status == ST_START || res.status == ST_BAD_RESTART)
        |=> phase_reg == PH_READ && count_reg == '0)
        else $error("frame start did not open a fresh frame");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res.last_payload |-> res.status == ST_PAYLOAD && phase_reg == PH_READ)
        else $error("last flag outside payload byte");

endmodule

>>> hdl/fld_out_stage.sv
// ----------------------------------------------------------------------------
// fld_out_stage
// Result register holding one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module fld_out_stage
    import fld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    room,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign room       = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> hdl/fixed_length_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// fixed_length_frame_deframer_core
// Start/end delimited fixed-length frame deframer, one byte in, one result out.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry rx_byte, one received byte per
//   transfer. output channel: out_valid / out_stall carry one result per
//   input byte: status, payload_byte, payload_index, last_payload.
//   status: ignored, frame start, payload byte, frame accepted, footer bad
//   restart (new frame opens at once), footer bad discard (back to hunting).
//   downstream commits or drops the streamed payload on the footer status.
//   configuration: cfg_we writes cfg_data into register cfg_index
//   (0 start byte, 1 end byte, 2 payload length); write only while idle.
//   path: a transferred byte passes through the input register, then the
//   result register; throughput one byte per cycle while out_stall stays low,
//   set by the single decode step between the two registers.
//   reset: hunting for a start byte, count zero, registers at 2 / 3 / 256,
//   both pipeline registers empty.
//   stall: a held result keeps the result register; one more byte waits in
//   the input register, after which in_stall rises until the result goes.
// ----------------------------------------------------------------------------
module fixed_length_frame_deframer_core
    import fld_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    // byte input
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    // result output
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [BYTE_W-1:0] payload_byte,
    output logic [IDX_W-1:0]  payload_index,
    output logic              last_payload
);

    // configuration registers
    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] end_byte_reg;
    logic [LEN_W-1:0]  payload_length_reg;

    in_xfer_t xfer;
    result_t  res;
    result_t  res_out;
    logic     out_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg     <= START_BYTE_RST;
            end_byte_reg       <= END_BYTE_RST;
            payload_length_reg <= PAYLOAD_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            // writes to an index beyond the list are dropped
            unique case (cfg_index)
                REG_START_BYTE:     start_byte_reg     <= cfg_data[BYTE_W-1:0];
                REG_END_BYTE:       end_byte_reg       <= cfg_data[BYTE_W-1:0];
                REG_PAYLOAD_LENGTH: payload_length_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // input register, refills in the cycle its byte moves on
    fld_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .out_room (out_room),
        .xfer     (xfer)
    );

    // frame phase, byte count and result decode
    fld_frame_fsm #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .xfer           (xfer),
        .start_byte     (start_byte_reg),
        .end_byte       (end_byte_reg),
        .payload_length (payload_length_reg),
        .res            (res)
    );

    // result register toward the receiver
    fld_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (xfer.advance),
        .res       (res),
        .room      (out_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign status        = res_out.status;
    assign payload_byte  = res_out.payload_byte;
    assign payload_index = res_out.payload_index;
    assign last_payload  = res_out.last_payload;

endmodule
